[hw/rtl/ppm_pkg.sv]
// Shared types, codes and constants of the PPM P6 stream decoder.
`timescale 1ns / 1ps

package ppm_pkg;

    // Largest accepted image dimension and the default depth of the job queue.
    localparam int PPM_MAX_DIM     = 4096;
    localparam int PPM_QUEUE_DEPTH = 4;

    // Character codes that the header parser recognizes.
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Header number limits.
    localparam logic [12:0] NUM_SAT_LIMIT = 13'd8191;
    localparam logic [12:0] MAXVAL_OK     = 13'd255;

    // Result kinds.
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // End-of-stream status codes.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_MAGIC  = 2'd1,
        ST_BAD_HEADER = 2'd2,
        ST_TRUNCATED  = 2'd3
    } t_status;

    // Parser phases, one-hot.
    typedef enum logic [7:0] {
        PH_MAGIC_P = 8'b0000_0001,
        PH_MAGIC_6 = 8'b0000_0010,
        PH_SKIP    = 8'b0000_0100,
        PH_NUM     = 8'b0000_1000,
        PH_COMMENT = 8'b0001_0000,
        PH_PIXELS  = 8'b0010_0000,
        PH_DONE    = 8'b0100_0000,
        PH_ERROR   = 8'b1000_0000
    } t_phase;

    // One queue entry: the results that one input byte causes.
    typedef struct packed {
        logic        has_pixel;
        logic        has_status;
        logic [23:0] color;
        logic [11:0] col;
        logic [11:0] row;
        t_status     status;
        logic [12:0] width;
        logic [12:0] height;
    } t_job;

endpackage

[hw/rtl/ppm_stream_if.sv]
// Valid/ready channel interfaces for the byte input and the result output.
`timescale 1ns / 1ps

interface ppm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface ppm_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [23:0] color;
    logic [11:0] col;
    logic [11:0] row;
    logic [1:0]  status;
    logic [12:0] width;
    logic [12:0] height;
    logic        run_end;

    modport source (output valid, output kind, output color, output col, output row,
                    output status, output width, output height, output run_end,
                    input ready);
    modport sink   (input valid, input kind, input color, input col, input row,
                    input status, input width, input height, input run_end,
                    output ready);
endinterface

[hw/rtl/ppm_front.sv]
// Front part: accepts bytes, parses the header, packs pixels and queues result jobs.
`timescale 1ns / 1ps

module ppm_front
    import ppm_pkg::*;
#(
    parameter int MAX_DIM = PPM_MAX_DIM
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ppm_byte_if.sink      i_in,
    input  logic          i_full,
    output logic          o_push,
    output t_job          o_job
);

    t_phase      r_phase,  n_phase;
    logic [1:0]  r_field,  n_field;
    logic [12:0] r_acc,    n_acc;
    logic [12:0] r_width,  n_width;
    logic [12:0] r_height, n_height;
    logic [1:0]  r_bip,    n_bip;
    logic [15:0] r_pc,     n_pc;
    logic [11:0] r_col,    n_col;
    logic [11:0] r_row,    n_row;
    t_status     r_err,    n_err;

    logic        accept;
    logic [7:0]  b;
    logic        is_space;
    logic        is_digit;
    logic [7:0]  digit_full;
    logic [16:0] num_next;
    logic [12:0] col_next;
    logic [12:0] row_next;
    logic        dims_ok;
    logic        hdr_ok;

    // A byte transfer completes whenever the queue has room.
    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.data_byte;

    // Byte classes and the decimal accumulate step.
    assign is_space   = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    assign is_digit   = (b >= CH_ZERO) && (b <= CH_NINE);
    assign digit_full = b - CH_ZERO;
    assign num_next   = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                        + {13'b0, digit_full[3:0]};
    assign col_next   = {1'b0, r_col} + 13'd1;
    assign row_next   = {1'b0, r_row} + 13'd1;
    assign dims_ok    = (r_width  >= 13'd1) && (r_width  <= 13'(MAX_DIM)) &&
                        (r_height >= 13'd1) && (r_height <= 13'(MAX_DIM));
    assign hdr_ok     = dims_ok && (r_acc == MAXVAL_OK) && (b != CH_HASH);

    // Parser next state and the job for this byte.
    always_comb begin
        logic accepted;
        n_phase  = r_phase;
        n_field  = r_field;
        n_acc    = r_acc;
        n_width  = r_width;
        n_height = r_height;
        n_bip    = r_bip;
        n_pc     = r_pc;
        n_col    = r_col;
        n_row    = r_row;
        n_err    = r_err;
        o_job    = '0;
        o_push   = 1'b0;
        accepted = 1'b0;

        if (accept) begin
            unique case (r_phase)
                PH_MAGIC_P: begin
                    if (b == CH_P) begin
                        n_phase = PH_MAGIC_6;
                    end else begin
                        n_err   = ST_BAD_MAGIC;
                        n_phase = PH_ERROR;
                    end
                end
                PH_MAGIC_6: begin
                    if (b == CH_SIX) begin
                        n_phase = PH_SKIP;
                    end else begin
                        n_err   = ST_BAD_MAGIC;
                        n_phase = PH_ERROR;
                    end
                end
                PH_SKIP: begin
                    if (is_space) begin
                        n_phase = PH_SKIP;
                    end else if (b == CH_HASH) begin
                        n_phase = PH_COMMENT;
                    end else if (is_digit) begin
                        n_acc   = {9'b0, digit_full[3:0]};
                        n_phase = PH_NUM;
                    end else begin
                        n_err   = ST_BAD_HEADER;
                        n_phase = PH_ERROR;
                    end
                end
                PH_COMMENT: begin
                    if ((b == CH_LF) || (b == CH_CR)) begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_NUM: begin
                    if (is_digit) begin
                        n_acc = (num_next > {4'b0, NUM_SAT_LIMIT}) ? NUM_SAT_LIMIT
                                                                   : num_next[12:0];
                    end else if (is_space || (b == CH_HASH)) begin
                        // The terminator closes width, height or maxval.
                        if (r_field == 2'd0) begin
                            n_width = r_acc;
                            n_field = 2'd1;
                            n_phase = (b == CH_HASH) ? PH_COMMENT : PH_SKIP;
                        end else if (r_field == 2'd1) begin
                            n_height = r_acc;
                            n_field  = 2'd2;
                            n_phase  = (b == CH_HASH) ? PH_COMMENT : PH_SKIP;
                        end else if (hdr_ok) begin
                            n_phase = PH_PIXELS;
                            n_bip   = 2'd0;
                            n_pc    = '0;
                            n_col   = '0;
                            n_row   = '0;
                        end else begin
                            n_err   = ST_BAD_HEADER;
                            n_phase = PH_ERROR;
                        end
                    end else begin
                        n_err   = ST_BAD_HEADER;
                        n_phase = PH_ERROR;
                    end
                end
                PH_PIXELS: begin
                    if (r_bip != 2'd2) begin
                        n_pc  = {r_pc[7:0], b};
                        n_bip = r_bip + 2'd1;
                    end else begin
                        // Third byte completes a pixel; advance column and row.
                        o_job.has_pixel = 1'b1;
                        o_job.color     = {r_pc, b};
                        o_job.col       = r_col;
                        o_job.row       = r_row;
                        n_bip           = 2'd0;
                        n_pc            = '0;
                        if (col_next >= r_width) begin
                            n_col = '0;
                            if (row_next >= r_height) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_row = row_next[11:0];
                            end
                        end else begin
                            n_col = col_next[11:0];
                        end
                    end
                end
                PH_DONE, PH_ERROR: begin
                    n_phase = r_phase;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            // Dimensions are reported once the header has been accepted.
            accepted     = (n_phase == PH_PIXELS) || (n_phase == PH_DONE);
            o_job.width  = accepted ? n_width  : '0;
            o_job.height = accepted ? n_height : '0;

            // The final byte adds a status result and rearms the parser.
            if (i_in.stream_end) begin
                o_job.has_status = 1'b1;
                if (n_phase == PH_ERROR) begin
                    o_job.status = n_err;
                end else if (n_phase == PH_DONE) begin
                    o_job.status = ST_OK;
                end else begin
                    o_job.status = ST_TRUNCATED;
                end
                n_phase  = PH_MAGIC_P;
                n_field  = '0;
                n_acc    = '0;
                n_width  = '0;
                n_height = '0;
                n_bip    = '0;
                n_pc     = '0;
                n_col    = '0;
                n_row    = '0;
                n_err    = ST_OK;
            end

            o_push = o_job.has_pixel || o_job.has_status;
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC_P;
            r_field  <= '0;
            r_acc    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_bip    <= '0;
            r_pc     <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_err    <= ST_OK;
        end else begin
            r_phase  <= n_phase;
            r_field  <= n_field;
            r_acc    <= n_acc;
            r_width  <= n_width;
            r_height <= n_height;
            r_bip    <= n_bip;
            r_pc     <= n_pc;
            r_col    <= n_col;
            r_row    <= n_row;
            r_err    <= n_err;
        end
    end

endmodule

[hw/rtl/ppm_fifo.sv]
// Short job queue between the parser and the result emitter.
`timescale 1ns / 1ps

module ppm_fifo
    import ppm_pkg::*;
#(
    parameter int DEPTH = PPM_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr,  n_wr;
    logic [PW-1:0] r_rd,  n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    // Pointer and fill count updates.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job popped from an empty queue");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not follow a lone push");
`endif

endmodule

[hw/rtl/ppm_back.sv]
// Back part: turns queued jobs into result transfers through an output register.
`timescale 1ns / 1ps

module ppm_back
    import ppm_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_job           i_job,
    input  logic           i_empty,
    output logic           o_pop,
    ppm_result_if.source   o_out
);

    logic        r_valid,  n_valid;
    logic        r_second, n_second;
    logic        r_kind,   n_kind;
    logic [23:0] r_color,  n_color;
    logic [11:0] r_col,    n_col;
    logic [11:0] r_row,    n_row;
    t_status     r_status, n_status;
    logic [12:0] r_width,  n_width;
    logic [12:0] r_height, n_height;
    logic        r_run_end, n_run_end;
    logic        load;

    // The output register takes a new result when empty or being drained.
    assign load = !r_valid || o_out.ready;

    // Pick the next result of the head job: pixel first, then status.
    always_comb begin
        n_valid   = r_valid && !o_out.ready;
        n_second  = r_second;
        n_kind    = r_kind;
        n_color   = r_color;
        n_col     = r_col;
        n_row     = r_row;
        n_status  = r_status;
        n_width   = r_width;
        n_height  = r_height;
        n_run_end = r_run_end;
        o_pop     = 1'b0;

        if (load && !i_empty) begin
            n_valid  = 1'b1;
            n_width  = i_job.width;
            n_height = i_job.height;
            if (i_job.has_pixel && !r_second) begin
                n_kind    = KIND_PIXEL;
                n_color   = i_job.color;
                n_col     = i_job.col;
                n_row     = i_job.row;
                n_status  = ST_OK;
                n_run_end = !i_job.has_status;
                n_second  = i_job.has_status;
                o_pop     = !i_job.has_status;
            end else begin
                n_kind    = KIND_STATUS;
                n_color   = '0;
                n_col     = '0;
                n_row     = '0;
                n_status  = i_job.status;
                n_run_end = 1'b1;
                n_second  = 1'b0;
                o_pop     = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_color   <= n_color;
        r_col     <= n_col;
        r_row     <= n_row;
        r_status  <= n_status;
        r_width   <= n_width;
        r_height  <= n_height;
        r_run_end <= n_run_end;
    end

    assign o_out.valid   = r_valid;
    assign o_out.kind    = r_kind;
    assign o_out.color   = r_color;
    assign o_out.col     = r_col;
    assign o_out.row     = r_row;
    assign o_out.status  = r_status;
    assign o_out.width   = r_width;
    assign o_out.height  = r_height;
    assign o_out.run_end = r_run_end;

`ifndef SYNTHESIS
    a_status_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_kind == KIND_STATUS)) |-> r_run_end)
        else $error("status result without run end");

    a_second_after_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (r_valid && (r_kind == KIND_PIXEL) && !r_run_end))
        else $error("pending status not preceded by an open pixel result");
`endif

endmodule

[hw/rtl/ppm_p6_stream_decoder_core.sv]
// Top level of the PPM P6 stream decoder: parser, job queue and result emitter.
//
//   Channel | Dir | Payload                                              | Transfer
//   i_in    | in  | data_byte[7:0], stream_end                           | valid & ready
//   o_out   | out | kind, color[23:0], col[11:0], row[11:0], status[1:0],| valid & ready
//           |     | width[12:0], height[12:0], run_end                   |
//
// One byte can be taken every cycle while the job queue has room; the parser
// finishes each byte in that cycle. Results leave at one per cycle from the output
// register while o_out.ready is high; a final byte that also completes a pixel
// yields two results, pixel then status. The job queue (QUEUE_DEPTH entries) lets
// input and output stall independently. Reset is synchronous and active low;
// no clearing pass is needed afterwards. Results are queued, then registered.
`timescale 1ns / 1ps

module ppm_p6_stream_decoder_core
    import ppm_pkg::*;
#(
    parameter int MAX_DIM     = PPM_MAX_DIM,
    parameter int QUEUE_DEPTH = PPM_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ppm_byte_if.sink      i_in,
    ppm_result_if.source  o_out
);

    t_job push_job;
    t_job head_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    ppm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    ppm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    ppm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
